### rtl/hsvrh_pkg.sv
// Shared constants, types and codes of the HSV region histogram.
`default_nettype none
package hsvrh_pkg;

  localparam int HUE_BINS   = 10;
  localparam int SAT_BINS   = 10;
  localparam int VAL_BINS   = 10;
  localparam int COUNT_BITS = 25;

  localparam int NBINS  = HUE_BINS * SAT_BINS + VAL_BINS;
  localparam int ADDR_W = $clog2(NBINS);

  localparam int BIN_W   = 7;
  localparam int RES_W   = 30;
  localparam int HUE_W   = 16;
  localparam int FRAC_W  = 13;
  localparam int POS_W   = 12;
  localparam int RECT_W  = 64;
  localparam int THR_W   = 13;
  localparam int HUE_X_W = 23;
  localparam int FRAC_X_W = 20;
  localparam int UNIT_SHIFT = 12;
  localparam int HUE_FULL = 46080;

  localparam int HEAVY_LO = 80;
  localparam int HEAVY_HI = 100;
  localparam int HEAVY_W  = 40;
  localparam int PROD_W   = COUNT_BITS + 6;

  localparam logic [RES_W-1:0]      MAX30     = {RES_W{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [THR_W-1:0] SAT_THR_RST = THR_W'(410);
  localparam logic [THR_W-1:0] VAL_THR_RST = THR_W'(819);

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    MODE_PIXEL    = 2'd0,
    MODE_CLEAR    = 2'd1,
    MODE_READ_RAW = 2'd2,
    MODE_READ_WGT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_OUTER_RECT = 2'd0,
    REG_INNER_RECT = 2'd1,
    REG_SAT_THR    = 2'd2,
    REG_VAL_THR    = 2'd3
  } reg_idx_t;

  // pixel bin lookup result
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              in_area;
  } bin_info_t;

  // word held between the memory read and the update
  typedef struct packed {
    mode_t             mode;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic              in_area;
    logic [BIN_W-1:0]  sel;
  } s1_t;

  // one finished result word
  typedef struct packed {
    logic [RES_W-1:0] weighted_total;
    logic [RES_W-1:0] bin_count;
    logic             counted;
    logic [BIN_W-1:0] bin_used;
  } result_t;

endpackage
`default_nettype wire

### rtl/hsvrh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hsvrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/hsvrh_bin_map.sv
// Pixel to bin mapping and region test (ring of outer minus inner rectangle).
`default_nettype none
module hsvrh_bin_map import hsvrh_pkg::*; (
  input  wire logic [POS_W-1:0]  row,
  input  wire logic [POS_W-1:0]  col,
  input  wire logic [HUE_W-1:0]  hue,
  input  wire logic [FRAC_W-1:0] sat,
  input  wire logic [FRAC_W-1:0] val,
  input  wire logic [RECT_W-1:0] outer_rect,
  input  wire logic [RECT_W-1:0] inner_rect,
  input  wire logic [THR_W-1:0]  sat_thr,
  input  wire logic [THR_W-1:0]  val_thr,
  output bin_info_t              info
);

  logic [HUE_X_W-1:0]  hue_x;
  logic [FRAC_X_W-1:0] sat_x;
  logic [FRAC_X_W-1:0] val_x;
  logic [ADDR_W-1:0]   hd;
  logic [ADDR_W-1:0]   sd;
  logic [ADDR_W-1:0]   vd;
  logic [ADDR_W-1:0]   sd_raw;
  logic [ADDR_W-1:0]   vd_raw;

  logic signed [17:0] r_s, c_s;
  logic signed [17:0] ox, oy, ow, oh, ix, iy, iw, ih;
  logic               in_outer, in_inner;

  assign hue_x = HUE_X_W'(hue) * HUE_X_W'(HUE_BINS);
  assign sat_x = FRAC_X_W'(sat) * FRAC_X_W'(SAT_BINS);
  assign val_x = FRAC_X_W'(val) * FRAC_X_W'(VAL_BINS);

  // hue digit: highest k with hue*HUE_BINS >= k*HUE_FULL
  always_comb begin
    hd = '0;
    for (int k = 1; k < HUE_BINS; k++) begin
      if (hue_x >= HUE_X_W'(k * HUE_FULL)) begin
        hd = ADDR_W'(k);
      end
    end
  end

  assign sd_raw = ADDR_W'(sat_x >> UNIT_SHIFT);
  assign vd_raw = ADDR_W'(val_x >> UNIT_SHIFT);
  assign sd = ((sat_x >> UNIT_SHIFT) > FRAC_X_W'(SAT_BINS - 1)) ? ADDR_W'(SAT_BINS - 1)
                                                                : sd_raw;
  assign vd = ((val_x >> UNIT_SHIFT) > FRAC_X_W'(VAL_BINS - 1)) ? ADDR_W'(VAL_BINS - 1)
                                                                : vd_raw;

  always_comb begin
    if ((sat < sat_thr) || (val < val_thr)) begin
      info.addr = ADDR_W'(HUE_BINS * SAT_BINS) + vd;
    end else begin
      info.addr = ADDR_W'(sd * ADDR_W'(HUE_BINS)) + hd;
    end
  end

  assign r_s = 18'(signed'({1'b0, row}));
  assign c_s = 18'(signed'({1'b0, col}));
  assign ox  = 18'(signed'(outer_rect[15:0]));
  assign oy  = 18'(signed'(outer_rect[31:16]));
  assign ow  = 18'(signed'({1'b0, outer_rect[47:32]}));
  assign oh  = 18'(signed'({1'b0, outer_rect[63:48]}));
  assign ix  = 18'(signed'(inner_rect[15:0]));
  assign iy  = 18'(signed'(inner_rect[31:16]));
  assign iw  = 18'(signed'({1'b0, inner_rect[47:32]}));
  assign ih  = 18'(signed'({1'b0, inner_rect[63:48]}));

  assign in_outer = (r_s >= oy) && (r_s < oy + oh) && (c_s >= ox) && (c_s < ox + ow);
  // inner box is open on the low side, closed on the high side
  assign in_inner = (r_s > iy) && (r_s <= iy + ih) && (c_s > ix) && (c_s <= ix + iw);

  assign info.in_area = in_outer && !in_inner;

endmodule
`default_nettype wire

### rtl/hsvrh_count_upd.sv
// Bin read-modify-write: entry valid bits, write forwarding and running total.
`default_nettype none
module hsvrh_count_upd import hsvrh_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire s1_t                   s1,
  input  wire logic [COUNT_BITS-1:0] ram_q,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [COUNT_BITS-1:0]      wr_data,
  output result_t                    res
);

  logic [NBINS-1:0]      valid_r, valid_nxt;
  logic                  fwd_vld_r, fwd_vld_nxt;
  logic [ADDR_W-1:0]     fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [RES_W-1:0]      total_r, total_nxt;

  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cnt_now;
  logic                  heavy;
  logic [5:0]            weight;
  logic                  do_inc;
  logic [RES_W:0]        total_sum;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     cnt_sel;

  // entry never written since reset or clear reads as zero; the last write
  // is forwarded since its read may have raced it
  always_comb begin
    if (!s1.in_range || !valid_r[s1.addr]) begin
      cur = '0;
    end else if (fwd_vld_r && (fwd_addr_r == s1.addr)) begin
      cur = fwd_data_r;
    end else begin
      cur = ram_q;
    end
  end

  assign heavy  = (s1.addr >= ADDR_W'(HEAVY_LO)) && (s1.addr < ADDR_W'(HEAVY_HI));
  assign weight = heavy ? 6'(HEAVY_W) : 6'd1;

  assign do_inc  = (s1.mode == MODE_PIXEL) && s1.in_area && (cur != COUNT_MAX);
  assign cnt_now = do_inc ? cur + 1'b1 : cur;

  assign total_sum = (RES_W + 1)'(total_r) + (RES_W + 1)'(weight);

  assign prod    = PROD_W'(cur) * PROD_W'(weight);
  assign cnt_sel = (s1.mode == MODE_READ_WGT) ? prod : PROD_W'(cnt_now);

  always_comb begin
    res = '0;
    case (s1.mode)
      MODE_PIXEL: begin
        res.bin_used = BIN_W'(s1.addr);
        res.counted  = s1.in_area;
      end
      MODE_CLEAR: begin
        res.bin_used = '0;
      end
      MODE_READ_RAW, MODE_READ_WGT: begin
        res.bin_used = s1.sel;
      end
      default: begin
        res.bin_used = '0;
      end
    endcase
    if (s1.mode != MODE_CLEAR) begin
      if (64'(cnt_sel) > 64'(MAX30)) begin
        res.bin_count = MAX30;
      end else begin
        res.bin_count = RES_W'(cnt_sel);
      end
    end
    res.weighted_total = total_nxt;
  end

  always_comb begin
    valid_nxt   = valid_r;
    fwd_vld_nxt = fwd_vld_r;
    total_nxt   = total_r;
    if (s1.mode == MODE_CLEAR) begin
      valid_nxt   = '0;
      fwd_vld_nxt = 1'b0;
      total_nxt   = '0;
    end else if (do_inc) begin
      valid_nxt[s1.addr] = 1'b1;
      fwd_vld_nxt        = 1'b1;
      total_nxt          = total_sum[RES_W] ? MAX30 : total_sum[RES_W-1:0];
    end
  end

  assign wr_en   = adv && do_inc;
  assign wr_addr = s1.addr;
  assign wr_data = cnt_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      fwd_vld_r <= 1'b0;
      total_r   <= '0;
    end else if (adv) begin
      valid_r   <= valid_nxt;
      fwd_vld_r <= fwd_vld_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
  end

endmodule
`default_nettype wire

### rtl/hsv_region_histogram_unit.sv
// An accepted word is registered in the read stage, then updated into the output register.
// Throughput: one word per cycle while out_tready is high, including back-to-back pixels
// to the same bin (the last bin write is forwarded into the read-modify-write).
// A clear word drops the per-bin valid flops and the total.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes all bins and the total,
// and loads the register defaults; no memory sweep is needed.
`default_nettype none
module hsv_region_histogram_unit import hsvrh_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // cfg_index: 0 outer_rect, 1 inner_rect, 2 sat_threshold, 3 val_threshold
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [RECT_W-1:0]     cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // row[11:0], col[23:12], hue[39:24], sat[52:40], val[65:53], bin_select[72:66]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // bin_used[6:0], counted[7], bin_count[37:8], weighted_total[67:38]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic [RECT_W-1:0] outer_rect_r, inner_rect_r;
  logic [THR_W-1:0]  sat_thr_r, val_thr_r;

  logic [POS_W-1:0]  in_row, in_col;
  logic [HUE_W-1:0]  in_hue;
  logic [FRAC_W-1:0] in_sat, in_val;
  logic [BIN_W-1:0]  in_sel;
  mode_t             in_mode;
  logic              in_acc;

  bin_info_t         pix;
  s1_t               s1_nxt, s1_r;
  logic              s1_vld_r;
  logic              adv;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] ram_q;
  result_t               res;

  logic              out_vld_r;
  result_t           out_r;

  // configuration always taken; it applies to words accepted after the write edge
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_rect_r <= '0;
      inner_rect_r <= '0;
      sat_thr_r    <= SAT_THR_RST;
      val_thr_r    <= VAL_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_OUTER_RECT: outer_rect_r <= cfg_data;
        REG_INNER_RECT: inner_rect_r <= cfg_data;
        REG_SAT_THR:    sat_thr_r    <= cfg_data[THR_W-1:0];
        REG_VAL_THR:    val_thr_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_row  = in_tdata[11:0];
  assign in_col  = in_tdata[23:12];
  assign in_hue  = in_tdata[39:24];
  assign in_sat  = in_tdata[52:40];
  assign in_val  = in_tdata[65:53];
  assign in_sel  = in_tdata[72:66];
  assign in_mode = mode_t'(in_tuser);

  hsvrh_bin_map u_bin_map (
    .row        (in_row),
    .col        (in_col),
    .hue        (in_hue),
    .sat        (in_sat),
    .val        (in_val),
    .outer_rect (outer_rect_r),
    .inner_rect (inner_rect_r),
    .sat_thr    (sat_thr_r),
    .val_thr    (val_thr_r),
    .info       (pix)
  );

  always_comb begin
    s1_nxt.mode    = in_mode;
    s1_nxt.sel     = in_sel;
    s1_nxt.in_area = pix.in_area;
    if (in_mode == MODE_PIXEL) begin
      s1_nxt.addr     = pix.addr;
      s1_nxt.in_range = 1'b1;
    end else begin
      s1_nxt.addr     = ADDR_W'(in_sel);
      s1_nxt.in_range = (in_mode != MODE_CLEAR) && (32'(in_sel) < 32'(NBINS));
    end
  end

  // update stage moves on when the output register is free or being drained
  assign adv       = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  hsvrh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NBINS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (s1_nxt.addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  hsvrh_count_upd u_count_upd (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1      (s1_r),
    .ram_q   (ram_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_r);

endmodule
`default_nettype wire
